### rtl/core/salc_pkg.sv
package salc_pkg;

    // Default sizes handed to the top level.
    localparam int SALC_WAYS      = 8;
    localparam int SALC_SETS      = 64;
    localparam int SALC_ADDR_BITS = 32;

    // Register values after reset.
    localparam logic [3:0] WAYS_IN_USE_RST  = 4'd8;
    localparam logic [2:0] SET_BITS_RST     = 3'd6;
    localparam logic [2:0] OFFSET_BITS_RST  = 3'd4;

    // Register indexes on the configuration channel.
    localparam logic [1:0] CFG_WAYS_IN_USE       = 2'd0;
    localparam logic [1:0] CFG_SET_INDEX_BITS    = 2'd1;
    localparam logic [1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } salc_state_t;

    typedef struct packed {
        logic [3:0] ways_in_use;
        logic [2:0] set_index_bits;
        logic [2:0] block_offset_bits;
    } salc_cfg_t;

    // Completion of one access, raised for the cycle of the last write.
    typedef struct packed {
        logic       fin;
        logic       is_write;
        logic       hit;
        logic       evicted_dirty;
        logic [2:0] way;
    } salc_done_t;

endpackage

### rtl/core/salc_store.sv
module salc_store #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/salc_way_unit.sv
// Shared per-way unit: tag compare for the lookup pass and the new entry
// value (recency aging, fill, dirty marking) for the update pass.
module salc_way_unit #(
    parameter int WAYS   = 8,
    parameter int TAG_W  = 32,
    parameter int RANK_W = 3
) (
    input  logic              e_valid,
    input  logic              e_dirty,
    input  logic [RANK_W-1:0] e_rank,
    input  logic [TAG_W-1:0]  e_tag,
    input  logic [RANK_W-1:0] idx,
    input  logic [TAG_W-1:0]  blk_tag,
    input  logic [RANK_W-1:0] sel_way,
    input  logic [RANK_W-1:0] old_rank,
    input  logic              was_valid,
    input  logic              hit,
    input  logic              is_write,
    output logic              match,
    output logic              n_valid,
    output logic              n_dirty,
    output logic [RANK_W-1:0] n_rank,
    output logic [TAG_W-1:0]  n_tag
);

    localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(WAYS - 1);

    logic older;

    assign match = e_valid && (e_tag == blk_tag);
    assign older = e_valid && (!was_valid || (e_rank < old_rank)) && (e_rank < MAX_RANK);

    always_comb
    begin
        if (idx == sel_way)
        begin
            n_valid = 1'b1;
            n_dirty = hit ? (e_dirty | is_write) : is_write;
            n_rank  = '0;
            n_tag   = hit ? e_tag : blk_tag;
        end
        else
        begin
            n_valid = e_valid;
            n_dirty = e_dirty;
            n_rank  = older ? RANK_W'(e_rank + 1'b1) : e_rank;
            n_tag   = e_tag;
        end
    end

endmodule

### rtl/core/salc_ctrl.sv
module salc_ctrl
    import salc_pkg::*;
#(
    parameter int WAYS      = SALC_WAYS,
    parameter int SETS      = SALC_SETS,
    parameter int ADDR_BITS = SALC_ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        kind,
    input  logic [31:0] address,
    input  salc_cfg_t   cfg,
    output logic        busy,
    output salc_done_t  done
);

    localparam int IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = IDX_W;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SETS > 1) ? SET_BITS : 1;
    localparam int MEM_AW   = SET_W + IDX_W;
    localparam int ENTRY_W  = ADDR_BITS + RANK_W + 2;

    salc_state_t state_reg, state_next;
    logic [MEM_AW-1:0] clr_addr_reg, clr_addr_next;

    logic                 kind_reg, kind_next;
    logic [ADDR_BITS-1:0] tag_reg, tag_next;
    logic [SET_W-1:0]     set_reg, set_next;
    logic [CNT_W-1:0]     nways_reg, nways_next;

    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             dv_reg, dv_next;
    logic [IDX_W-1:0] didx_reg, didx_next;

    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_way_reg, hit_way_next;
    logic [RANK_W-1:0] hit_rank_reg, hit_rank_next;
    logic              empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]  empty_way_reg, empty_way_next;
    logic [RANK_W-1:0] best_rank_reg, best_rank_next;
    logic [IDX_W-1:0]  best_way_reg, best_way_next;
    logic              best_dirty_reg, best_dirty_next;
    logic [IDX_W-1:0]  sel_way_reg, sel_way_next;
    logic [RANK_W-1:0] old_rank_reg, old_rank_next;
    logic              was_valid_reg, was_valid_next;
    logic              wb_reg, wb_next;

    // Decoded configuration, taken when an access starts.
    logic [4:0]           ways5;
    logic [CNT_W-1:0]     nways_eff;
    logic [2:0]           sbits_eff;
    logic [31:0]          shifted;
    logic [63:0]          blk64;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] blk_tag;

    logic              issuing;
    logic              last;
    logic [3:0]        sel_way4;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [MEM_AW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic                 e_valid, e_dirty;
    logic [RANK_W-1:0]    e_rank;
    logic [ADDR_BITS-1:0] e_tag;
    logic                 match;
    logic                 n_valid, n_dirty;
    logic [RANK_W-1:0]    n_rank;
    logic [ADDR_BITS-1:0] n_tag;

    assign {e_valid, e_dirty, e_rank, e_tag} = rd_data;

    always_comb
    begin
        if (cfg.ways_in_use == 4'd0)
        begin
            ways5 = 5'd1;
        end
        else if ({1'b0, cfg.ways_in_use} > 5'(WAYS))
        begin
            ways5 = 5'(WAYS);
        end
        else
        begin
            ways5 = {1'b0, cfg.ways_in_use};
        end
        nways_eff = CNT_W'(ways5);

        if ({1'b0, cfg.set_index_bits} > 4'(SET_BITS))
        begin
            sbits_eff = 3'(SET_BITS);
        end
        else
        begin
            sbits_eff = cfg.set_index_bits;
        end

        shifted = address >> cfg.block_offset_bits;
        blk64   = {32'd0, shifted << cfg.block_offset_bits};
        blk_tag = blk64[ADDR_BITS-1:0];
        set_idx = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sbits_eff);
    end

    assign rd_addr  = {set_reg, issue_reg[IDX_W-1:0]};
    assign issuing  = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                      && (issue_reg < nways_reg);
    assign last     = dv_reg && (CNT_W'(didx_reg) == CNT_W'(nways_reg - 1'b1));
    assign sel_way4 = 4'(sel_way_reg);
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        kind_next        = kind_reg;
        tag_next         = tag_reg;
        set_next         = set_reg;
        nways_next       = nways_reg;
        issue_next       = issuing ? CNT_W'(issue_reg + 1'b1) : issue_reg;
        dv_next          = issuing;
        didx_next        = issue_reg[IDX_W-1:0];
        hit_next         = hit_reg;
        hit_way_next     = hit_way_reg;
        hit_rank_next    = hit_rank_reg;
        empty_found_next = empty_found_reg;
        empty_way_next   = empty_way_reg;
        best_rank_next   = best_rank_reg;
        best_way_next    = best_way_reg;
        best_dirty_next  = best_dirty_reg;
        sel_way_next     = sel_way_reg;
        old_rank_next    = old_rank_reg;
        was_valid_next   = was_valid_reg;
        wb_next          = wb_reg;
        wr_en            = 1'b0;
        wr_addr          = {set_reg, didx_reg};
        wr_data          = {n_valid, n_dirty, n_rank, n_tag};
        done             = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = MEM_AW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == {MEM_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next        = kind;
                    tag_next         = blk_tag;
                    set_next         = set_idx;
                    nways_next       = nways_eff;
                    issue_next       = '0;
                    dv_next          = 1'b0;
                    hit_next         = 1'b0;
                    empty_found_next = 1'b0;
                    wb_next          = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (dv_reg)
                begin
                    if (!e_valid)
                    begin
                        if (!empty_found_reg)
                        begin
                            empty_found_next = 1'b1;
                            empty_way_next   = didx_reg;
                        end
                    end
                    else if (!hit_reg && match)
                    begin
                        hit_next      = 1'b1;
                        hit_way_next  = didx_reg;
                        hit_rank_next = e_rank;
                    end
                    if ((didx_reg == '0) || (e_rank > best_rank_reg))
                    begin
                        best_rank_next  = e_rank;
                        best_way_next   = didx_reg;
                        best_dirty_next = e_dirty;
                    end
                end
                if (last)
                begin
                    // Pick the way to touch: the hit, the first empty way,
                    // or the least recently used victim.
                    if (hit_next)
                    begin
                        sel_way_next   = hit_way_next;
                        old_rank_next  = hit_rank_next;
                        was_valid_next = 1'b1;
                        wb_next        = 1'b0;
                    end
                    else if (empty_found_next)
                    begin
                        sel_way_next   = empty_way_next;
                        old_rank_next  = '0;
                        was_valid_next = 1'b0;
                        wb_next        = 1'b0;
                    end
                    else
                    begin
                        sel_way_next   = best_way_next;
                        old_rank_next  = best_rank_next;
                        was_valid_next = 1'b1;
                        wb_next        = best_dirty_next;
                    end
                    issue_next = '0;
                    dv_next    = 1'b0;
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (dv_reg)
                begin
                    wr_en = 1'b1;
                end
                if (last)
                begin
                    done.fin           = 1'b1;
                    done.is_write      = kind_reg;
                    done.hit           = hit_reg;
                    done.evicted_dirty = wb_reg;
                    done.way           = sel_way4[2:0];
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            issue_reg    <= '0;
            dv_reg       <= 1'b0;
            nways_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            issue_reg    <= issue_next;
            dv_reg       <= dv_next;
            nways_reg    <= nways_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        tag_reg         <= tag_next;
        set_reg         <= set_next;
        didx_reg        <= didx_next;
        hit_reg         <= hit_next;
        hit_way_reg     <= hit_way_next;
        hit_rank_reg    <= hit_rank_next;
        empty_found_reg <= empty_found_next;
        empty_way_reg   <= empty_way_next;
        best_rank_reg   <= best_rank_next;
        best_way_reg    <= best_way_next;
        best_dirty_reg  <= best_dirty_next;
        sel_way_reg     <= sel_way_next;
        old_rank_reg    <= old_rank_next;
        was_valid_reg   <= was_valid_next;
        wb_reg          <= wb_next;
    end

    salc_way_unit #(
        .WAYS   (WAYS),
        .TAG_W  (ADDR_BITS),
        .RANK_W (RANK_W)
    ) u_way_unit (
        .e_valid   (e_valid),
        .e_dirty   (e_dirty),
        .e_rank    (e_rank),
        .e_tag     (e_tag),
        .idx       (didx_reg),
        .blk_tag   (tag_reg),
        .sel_way   (sel_way_reg),
        .old_rank  (old_rank_reg),
        .was_valid (was_valid_reg),
        .hit       (hit_reg),
        .is_write  (kind_reg),
        .match     (match),
        .n_valid   (n_valid),
        .n_dirty   (n_dirty),
        .n_rank    (n_rank),
        .n_tag     (n_tag)
    );

    salc_store #(
        .DATA_W (ENTRY_W),
        .ADDR_W (MEM_AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### rtl/core/set_assoc_lru_writeback_cache.sv
// Tag and state engine of a set-associative, write-back, write-allocate cache
// with LRU replacement. An access (kind, address) is taken when start is high
// while busy is low; one result word follows for exactly one cycle, marked by
// result_valid, and cannot be held off by the receiver. The result word is
// shown in the same cycle as busy drops, so a new access is accepted only
// after the previous one is through: a single per-way compare and update
// unit walks the set twice through the one read port and one write port of
// the set memory, first looking up the tag and the replacement candidate,
// then writing back the aged recency ranks, dirty bits and the filled tag.
// After reset the block clears every entry of the set memory and holds busy
// high meanwhile; configuration writes are taken at any time but should only
// be issued while the block is idle.
module set_assoc_lru_writeback_cache
    import salc_pkg::*;
#(
    parameter int WAYS      = SALC_WAYS,
    parameter int SETS      = SALC_SETS,
    parameter int ADDR_BITS = SALC_ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Access channel.
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [31:0] address,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // Result channel.
    output logic        result_valid,
    output logic        hit,
    output logic        evicted_dirty,
    output logic [2:0]  way_used,
    output logic [31:0] read_count,
    output logic [31:0] write_count,
    output logic [31:0] writeback_count,
    output logic [31:0] read_hit_count,
    output logic [31:0] write_hit_count,
    output logic [31:0] read_miss_count,
    output logic [31:0] write_miss_count
);

    salc_cfg_t  cfg_reg;
    salc_done_t done;

    logic        result_valid_reg;
    logic        hit_reg;
    logic        evicted_dirty_reg;
    logic [2:0]  way_used_reg;

    logic [31:0] read_count_reg;
    logic [31:0] write_count_reg;
    logic [31:0] writeback_count_reg;
    logic [31:0] read_hit_count_reg;
    logic [31:0] write_hit_count_reg;
    logic [31:0] read_miss_count_reg;
    logic [31:0] write_miss_count_reg;

    // The configuration registers never stall a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ways_in_use       <= WAYS_IN_USE_RST;
            cfg_reg.set_index_bits    <= SET_BITS_RST;
            cfg_reg.block_offset_bits <= OFFSET_BITS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WAYS_IN_USE:       cfg_reg.ways_in_use       <= cfg_data;
                CFG_SET_INDEX_BITS:    cfg_reg.set_index_bits    <= cfg_data[2:0];
                CFG_BLOCK_OFFSET_BITS: cfg_reg.block_offset_bits <= cfg_data[2:0];
                default:
                begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    // The event counters move only at the edge that finishes an access, so the
    // result word carries the totals including that access.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg     <= 1'b0;
            read_count_reg       <= '0;
            write_count_reg      <= '0;
            writeback_count_reg  <= '0;
            read_hit_count_reg   <= '0;
            write_hit_count_reg  <= '0;
            read_miss_count_reg  <= '0;
            write_miss_count_reg <= '0;
        end
        else
        begin
            result_valid_reg <= done.fin;
            if (done.fin)
            begin
                if (done.is_write)
                begin
                    write_count_reg <= write_count_reg + 32'd1;
                    if (done.hit)
                    begin
                        write_hit_count_reg <= write_hit_count_reg + 32'd1;
                    end
                    else
                    begin
                        write_miss_count_reg <= write_miss_count_reg + 32'd1;
                    end
                end
                else
                begin
                    read_count_reg <= read_count_reg + 32'd1;
                    if (done.hit)
                    begin
                        read_hit_count_reg <= read_hit_count_reg + 32'd1;
                    end
                    else
                    begin
                        read_miss_count_reg <= read_miss_count_reg + 32'd1;
                    end
                end
                if (done.evicted_dirty)
                begin
                    writeback_count_reg <= writeback_count_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.fin)
        begin
            hit_reg           <= done.hit;
            evicted_dirty_reg <= done.evicted_dirty;
            way_used_reg      <= done.way;
        end
    end

    salc_ctrl #(
        .WAYS      (WAYS),
        .SETS      (SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .address (address),
        .cfg     (cfg_reg),
        .busy    (busy),
        .done    (done)
    );

    assign result_valid     = result_valid_reg;
    assign hit              = hit_reg;
    assign evicted_dirty    = evicted_dirty_reg;
    assign way_used         = way_used_reg;
    assign read_count       = read_count_reg;
    assign write_count      = write_count_reg;
    assign writeback_count  = writeback_count_reg;
    assign read_hit_count   = read_hit_count_reg;
    assign write_hit_count  = write_hit_count_reg;
    assign read_miss_count  = read_miss_count_reg;
    assign write_miss_count = write_miss_count_reg;

endmodule

### rtl/core/salc_checker.sv
module salc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic        hit,
    input logic        evicted_dirty,
    input logic [31:0] read_count,
    input logic [31:0] write_count,
    input logic [31:0] read_hit_count,
    input logic [31:0] write_hit_count,
    input logic [31:0] read_miss_count,
    input logic [31:0] write_miss_count
);

    // An accepted access keeps the block busy until its result is out.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("access accepted but block not busy");

    // A result is shown only once the block has gone idle again.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // A hit never evicts anything.
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && hit) |-> !evicted_dirty)
        else $error("write-back reported on a hit");

    // Every read is either a hit or a miss, and likewise every write.
    a_read_split: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((read_hit_count + read_miss_count) == read_count))
        else $error("read hit and miss counts do not add up");

    a_write_split: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((write_hit_count + write_miss_count) == write_count))
        else $error("write hit and miss counts do not add up");

endmodule

bind set_assoc_lru_writeback_cache salc_checker u_salc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .result_valid     (result_valid),
    .hit              (hit),
    .evicted_dirty    (evicted_dirty),
    .read_count       (read_count),
    .write_count      (write_count),
    .read_hit_count   (read_hit_count),
    .write_hit_count  (write_hit_count),
    .read_miss_count  (read_miss_count),
    .write_miss_count (write_miss_count)
);

### bench/set_assoc_lru_writeback_cache_tb.sv
module set_assoc_lru_writeback_cache_tb;
    import salc_pkg::*;

    // Access kinds as carried on the kind port.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Geometry of the instance under test.
    localparam int SLOTS        = SALC_SETS * SALC_WAYS;
    localparam int MAX_SET_BITS = $clog2(SALC_SETS);
    localparam logic [2:0] OLDEST_RANK = 3'(SALC_WAYS - 1);

    // Run length and shape of the stimulus.
    localparam int DIRECTED_ROWS     = 24;
    localparam int SEGMENTS          = 12;
    localparam int ITEMS_PER_SEGMENT = 95;
    localparam int POOL_MAX          = 24;
    localparam int LONGEST_GAP       = 24;
    localparam int CYCLE_LIMIT       = 400000;

    // Event counters in the order in which the block reports them.
    typedef enum int {
        TALLY_READ,
        TALLY_WRITE,
        TALLY_WRITEBACK,
        TALLY_READ_HIT,
        TALLY_WRITE_HIT,
        TALLY_READ_MISS,
        TALLY_WRITE_MISS
    } tally_t;

    // One expected result word.
    typedef struct packed {
        logic            hit;
        logic            evicted_dirty;
        logic [2:0]      way;
        logic [6:0][31:0] tally;
    } outcome_t;

    // One line of the directed script. A setup line writes all three registers;
    // any other line is an access, with hit, write-back and way typed in when
    // the typed flag is set.
    typedef struct packed {
        logic        setup;
        logic [3:0]  ways;
        logic [3:0]  sets;
        logic [3:0]  offset;
        logic        kind;
        logic [31:0] addr;
        logic        typed;
        logic        hit;
        logic        evicted_dirty;
        logic [2:0]  way;
    } script_row_t;

    // Every input carries a known value from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        kind = 1'b0;
    logic [31:0] address = '0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    logic        busy;
    logic        cfg_ready;
    logic        result_valid;
    logic        hit;
    logic        evicted_dirty;
    logic [2:0]  way_used;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [31:0] writeback_count;
    logic [31:0] read_hit_count;
    logic [31:0] write_hit_count;
    logic [31:0] read_miss_count;
    logic [31:0] write_miss_count;

    set_assoc_lru_writeback_cache dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .address          (address),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .hit              (hit),
        .evicted_dirty    (evicted_dirty),
        .way_used         (way_used),
        .read_count       (read_count),
        .write_count      (write_count),
        .writeback_count  (writeback_count),
        .read_hit_count   (read_hit_count),
        .write_hit_count  (write_hit_count),
        .read_miss_count  (read_miss_count),
        .write_miss_count (write_miss_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the cache state. The registers start at their reset
    // values and every line starts invalid, clean and most recent.
    logic [3:0]  ways_reg     = WAYS_IN_USE_RST;
    logic [2:0]  set_bits_reg = SET_BITS_RST;
    logic [2:0]  offset_reg   = OFFSET_BITS_RST;
    bit   [31:0] line_tag   [SLOTS];
    bit          line_valid [SLOTS];
    bit          line_dirty [SLOTS];
    bit   [2:0]  line_rank  [SLOTS];
    bit   [31:0] event_tally [7];

    outcome_t    awaited_outcomes [$];
    int          failures = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    bit          start_high = 1'b0;
    script_row_t script [DIRECTED_ROWS];

    // The counters as one packed vector, read_count at index zero.
    wire [6:0][31:0] seen_tally = {write_miss_count, read_miss_count, write_hit_count,
                                   read_hit_count, writeback_count, write_count,
                                   read_count};
    string tally_name [7] = '{"read_count", "write_count", "writeback_count",
                              "read_hit_count", "write_hit_count", "read_miss_count",
                              "write_miss_count"};

    // Recency update for an access to way w of the set at base. Valid in-use
    // ways younger than w age by one; when w was empty, every valid in-use way
    // ages. Ranks saturate at the oldest rank, and w becomes the most recent.
    function automatic void age_ranks(input int base, input int nways, input int w,
                                      input bit was_valid);
        int         i;
        logic [2:0] old_rank;
        old_rank = line_rank[base + w];
        for (i = 0; i < nways; i++)
        begin
            if (i != w && line_valid[base + i]
                    && (!was_valid || line_rank[base + i] < old_rank)
                    && line_rank[base + i] < OLDEST_RANK)
                line_rank[base + i] = line_rank[base + i] + 3'd1;
        end
        line_rank[base + w] = '0;
    endfunction

    // Looks one access up in the shadow cache, updates it and returns the
    // result word the block should report for it.
    function automatic outcome_t cache_access_outcome(input logic is_write,
                                                      input logic [31:0] addr);
        int          nways;
        int          sbits;
        int          obits;
        int          base;
        int          i;
        int          way;
        int          empty_way;
        bit          found_hit;
        bit          found_empty;
        bit          was_valid;
        logic [31:0] blk;
        logic [31:0] set_no;
        logic [2:0]  best;
        outcome_t    res;

        // Zero ways behaves as one way, and more ways than exist as all of them.
        nways = (ways_reg == 4'd0) ? 1 :
                (int'(ways_reg) > SALC_WAYS) ? SALC_WAYS : int'(ways_reg);
        sbits = (int'(set_bits_reg) > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
        obits = int'(offset_reg);
        blk    = (addr >> obits) << obits;
        set_no = (addr >> obits) & ((32'd1 << sbits) - 32'd1);
        base   = int'(set_no) * SALC_WAYS;
        res = '0;
        way = 0;
        empty_way = 0;
        found_hit = 1'b0;
        found_empty = 1'b0;

        if (is_write == KIND_WRITE)
            event_tally[TALLY_WRITE]++;
        else
            event_tally[TALLY_READ]++;

        // Tags of invalid ways are never looked at.
        for (i = 0; i < nways; i++)
        begin
            if (!line_valid[base + i])
            begin
                if (!found_empty)
                begin
                    found_empty = 1'b1;
                    empty_way = i;
                end
            end
            else if (!found_hit && line_tag[base + i] == blk)
            begin
                found_hit = 1'b1;
                way = i;
            end
        end

        if (found_hit)
        begin
            age_ranks(base, nways, way, 1'b1);
            if (is_write == KIND_WRITE)
            begin
                line_dirty[base + way] = 1'b1;
                event_tally[TALLY_WRITE_HIT]++;
            end
            else
                event_tally[TALLY_READ_HIT]++;
        end
        else
        begin
            if (is_write == KIND_WRITE)
                event_tally[TALLY_WRITE_MISS]++;
            else
                event_tally[TALLY_READ_MISS]++;
            if (found_empty)
                way = empty_way;
            else
            begin
                // The first way holding the oldest rank is the victim.
                best = line_rank[base];
                for (i = 1; i < nways; i++)
                begin
                    if (line_rank[base + i] > best)
                    begin
                        best = line_rank[base + i];
                        way = i;
                    end
                end
            end
            was_valid = line_valid[base + way];
            if (was_valid && line_dirty[base + way])
            begin
                res.evicted_dirty = 1'b1;
                event_tally[TALLY_WRITEBACK]++;
            end
            age_ranks(base, nways, way, was_valid);
            line_tag[base + way]   = blk;
            line_valid[base + way] = 1'b1;
            line_dirty[base + way] = (is_write == KIND_WRITE);
        end

        res.hit = found_hit;
        res.way = 3'(way);
        for (i = 0; i < 7; i++)
            res.tally[i] = event_tally[i];
        return res;
    endfunction

    function automatic script_row_t plain_access(input logic k, input logic [31:0] a);
        script_row_t row;
        row = '0;
        row.kind = k;
        row.addr = a;
        return row;
    endfunction

    function automatic script_row_t checked_access(input logic k, input logic [31:0] a,
                                                   input logic h, input logic wb,
                                                   input logic [2:0] w);
        script_row_t row;
        row = plain_access(k, a);
        row.typed = 1'b1;
        row.hit = h;
        row.evicted_dirty = wb;
        row.way = w;
        return row;
    endfunction

    function automatic script_row_t setup_row(input logic [3:0] w, input logic [3:0] s,
                                              input logic [3:0] o);
        script_row_t row;
        row = '0;
        row.setup = 1'b1;
        row.ways = w;
        row.sets = s;
        row.offset = o;
        return row;
    endfunction

    // Drops start unless it is already low, so that start never gets two
    // assignments at the same edge.
    task automatic lower_start();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    // Presents one access word and waits for the block to take it. The
    // expectation is queued at the accepting edge; afterwards the sender may
    // idle, cycle by cycle, driving junk on the payload meanwhile.
    task automatic issue_access(input script_row_t row);
        outcome_t want;
        int       gap;
        start <= 1'b1;
        start_high = 1'b1;
        kind <= row.kind;
        address <= row.addr;
        do
            @(posedge clk);
        while (busy);
        want = cache_access_outcome(row.kind, row.addr);
        if (row.typed)
        begin
            want.hit = row.hit;
            want.evicted_dirty = row.evicted_dirty;
            want.way = row.way;
        end
        awaited_outcomes.push_back(want);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            lower_start();
            kind <= 1'($urandom_range(1));
            address <= $urandom;
            gap = 0;
            do
            begin
                @(posedge clk);
                gap++;
            end
            while (gap < LONGEST_GAP && $urandom_range(99) < sender_idle_pct);
        end
    endtask

    // One register write on the configuration channel. Valid stays high on
    // return so that back-to-back writes need no lowering in between.
    task automatic put_register(input logic [1:0] idx, input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WAYS_IN_USE:       ways_reg = value;
            CFG_SET_INDEX_BITS:    set_bits_reg = value[2:0];
            CFG_BLOCK_OFFSET_BITS: offset_reg = value[2:0];
            default: ;
        endcase
    endtask

    // Writes a full setting once the block is idle and every word it owes
    // has come out.
    task automatic write_setup(input logic [3:0] w, input logic [3:0] s,
                               input logic [3:0] o);
        while (awaited_outcomes.size() != 0 || busy)
            @(posedge clk);
        put_register(CFG_WAYS_IN_USE, w);
        put_register(CFG_SET_INDEX_BITS, s);
        put_register(CFG_BLOCK_OFFSET_BITS, o);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            failures++;
        end
    endtask

    // Result checker. Each strobed word is matched against the oldest
    // expectation; a word with nothing waiting is an error on its own.
    always @(posedge clk)
    begin
        outcome_t want;
        int       i;
        if (rst_n && result_valid)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got hit %0d way %0d",
                         $time, hit, way_used);
                failures++;
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                compare_field("hit", 32'(want.hit), 32'(hit));
                compare_field("evicted_dirty", 32'(want.evicted_dirty), 32'(evicted_dirty));
                compare_field("way_used", 32'(want.way), 32'(way_used));
                for (i = 0; i < 7; i++)
                    compare_field(tally_name[i], want.tally[i], seen_tally[i]);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          seg;
        int          n;
        int          pool_size;
        int          eff_sbits;
        int          eff_obits;
        logic [3:0]  ways_pick;
        logic [3:0]  sets_pick;
        logic [3:0]  offset_pick;
        logic [31:0] set_field;
        logic [31:0] line_field;
        logic [31:0] hot_set [2];
        logic [31:0] pool [POOL_MAX];
        logic [31:0] addr_pick;

        // Directed script. The first rows run on the reset setting, so their
        // outcome is plain: an empty cache misses into way 0 and the same
        // block then hits. With one way in use (zero ways written) the next
        // conflicting read must evict the dirty line; then, with all eight
        // ways back (fifteen written), the next fill lands in the first empty
        // way. The rest exercise set bits beyond the array, block offsets
        // outside the normal range, eviction of the oldest way, and ways that
        // come back into use with their old contents.
        script = '{
            checked_access(KIND_READ,  32'h0000_0000, 1'b0, 1'b0, 3'd0),
            checked_access(KIND_WRITE, 32'h0000_0000, 1'b1, 1'b0, 3'd0),
            checked_access(KIND_READ,  32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0),
            checked_access(KIND_WRITE, 32'hFFFF_FFF0, 1'b1, 1'b0, 3'd0),
            setup_row(4'd0, 4'd6, 4'd4),
            checked_access(KIND_READ,  32'h0000_0400, 1'b0, 1'b1, 3'd0),
            checked_access(KIND_WRITE, 32'h0000_0000, 1'b0, 1'b0, 3'd0),
            setup_row(4'd15, 4'd6, 4'd4),
            checked_access(KIND_READ,  32'h0000_0400, 1'b0, 1'b0, 3'd1),
            setup_row(4'd2, 4'd7, 4'd4),
            plain_access(KIND_WRITE, 32'h0000_0800),
            plain_access(KIND_READ,  32'h0000_0400),
            plain_access(KIND_READ,  32'h0000_0C00),
            setup_row(4'd8, 4'd6, 4'd0),
            plain_access(KIND_READ,  32'h0000_0001),
            plain_access(KIND_WRITE, 32'hFFFF_FFFF),
            setup_row(4'd1, 4'd0, 4'd7),
            plain_access(KIND_WRITE, 32'h1234_5678),
            plain_access(KIND_READ,  32'h1234_56FF),
            plain_access(KIND_READ,  32'h8000_0000),
            setup_row(4'd8, 4'd3, 4'd1),
            plain_access(KIND_READ,  32'h0000_0400),
            plain_access(KIND_WRITE, 32'h0000_0000),
            plain_access(KIND_WRITE, 32'h7FFF_FFFE)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its set memory after reset with busy high; the
        // first access simply waits for it through the handshake.
        sender_idle_pct = 0;
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (script[r].setup)
            begin
                lower_start();
                write_setup(script[r].ways, script[r].sets, script[r].offset);
            end
            else
                issue_access(script[r]);
        end
        lower_start();

        // Random part in three phases of sender idling: some, heavy, none.
        // Each segment runs on its own setting, the first of each phase on a
        // preset one, extreme in the last two. Most addresses come from a small
        // pool of blocks packed into two sets, so that hits, evictions and
        // write-backs are common; the rest are uniform over all addresses.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            sender_idle_pct = (seg < SEGMENTS / 3) ? 31 :
                              (seg < 2 * SEGMENTS / 3) ? 79 : 0;
            if (seg % 4 == 0)
            begin
                case (seg / 4)
                    0:
                    begin
                        ways_pick = WAYS_IN_USE_RST;
                        sets_pick = 4'(SET_BITS_RST);
                        offset_pick = 4'(OFFSET_BITS_RST);
                    end
                    1:
                    begin
                        ways_pick = 4'd1;
                        sets_pick = 4'd0;
                        offset_pick = 4'd2;
                    end
                    default:
                    begin
                        ways_pick = 4'd8;
                        sets_pick = 4'd6;
                        offset_pick = 4'd6;
                    end
                endcase
            end
            else
            begin
                // Full field range, so the masked and limited cases come up too.
                ways_pick = 4'($urandom_range(15));
                sets_pick = 4'($urandom_range(15));
                offset_pick = 4'($urandom_range(15));
            end
            write_setup(ways_pick, sets_pick, offset_pick);

            eff_obits = int'(offset_reg);
            eff_sbits = (int'(set_bits_reg) > MAX_SET_BITS) ? MAX_SET_BITS
                                                             : int'(set_bits_reg);
            set_field = ((32'd1 << eff_sbits) - 32'd1) << eff_obits;
            line_field = (32'd1 << eff_obits) - 32'd1;
            pool_size = $urandom_range(POOL_MAX, 3);
            hot_set[0] = $urandom;
            hot_set[1] = $urandom;
            for (n = 0; n < pool_size; n++)
                pool[n] = ($urandom & ~set_field) | ((hot_set[n % 2] << eff_obits) & set_field);

            for (n = 0; n < ITEMS_PER_SEGMENT; n++)
            begin
                if ($urandom_range(99) < 85)
                    addr_pick = pool[$urandom_range(pool_size - 1)] ^ ($urandom & line_field);
                else
                    addr_pick = $urandom;
                issue_access(plain_access(1'($urandom_range(1)), addr_pick));
            end
            lower_start();
        end

        // Drain, then give the block time to show any stray word.
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (2 * SALC_WAYS + 8) @(posedge clk);

        if (failures == 0 && awaited_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/salc_pkg.sv
rtl/core/salc_store.sv
rtl/core/salc_way_unit.sv
rtl/core/salc_ctrl.sv
rtl/core/set_assoc_lru_writeback_cache.sv
rtl/core/salc_checker.sv
bench/set_assoc_lru_writeback_cache_tb.sv
